/* hw/rtl/aecd_pkg.sv */
// ----------------------------------------------------------------------------
// aecd_pkg
// Shared types and constants of the alpha edge color dilation block.
// ----------------------------------------------------------------------------
package aecd_pkg;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_ALPHA_THRESHOLD = 2'd2;
  localparam logic [1:0] REG_PASS_PAIRS      = 2'd3;

  localparam logic [6:0] RST_IMAGE_WIDTH     = 7'd64;
  localparam logic [6:0] RST_IMAGE_HEIGHT    = 7'd64;
  localparam logic [7:0] RST_ALPHA_THRESHOLD = 8'd10;
  localparam logic [3:0] RST_PASS_PAIRS      = 4'd5;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // neighbor search order
  localparam logic [2:0] NBR_CENTER = 3'd0;
  localparam logic [2:0] NBR_UP     = 3'd1;
  localparam logic [2:0] NBR_LEFT   = 3'd2;
  localparam logic [2:0] NBR_RIGHT  = 3'd3;
  localparam logic [2:0] NBR_DOWN   = 3'd4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
    logic       in_last;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_last;
  } pixel_out_t;

  typedef struct packed {
    logic [6:0] image_width;
    logic [6:0] image_height;
    logic [7:0] alpha_threshold;
    logic [3:0] pass_pairs;
  } cfg_t;

  typedef struct packed {
    logic       dil;        // dilation pass addressing
    logic       rd;         // issue read at neighbor k
    logic       eval;       // read data valid
    logic [2:0] k;
    logic       wr_center;
    logic       wr_nbr;
    logic       adv;
    logic [4:0] pass;
    logic       merge;
    logic       mrg_wr;
  } cmd_t;

  typedef struct packed {
    logic       opaque;
    logic       last_pixel;
    logic [3:0] pass_pairs;
  } sts_t;

endpackage

/* hw/rtl/aecd_ctrl.sv */
// ----------------------------------------------------------------------------
// aecd_ctrl
// Sequencer for the dilation passes and the final merge.
// ----------------------------------------------------------------------------
module aecd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_go,
  input  aecd_pkg::sts_t sts,
  output aecd_pkg::cmd_t cmd,
  output logic          busy
);

  typedef enum logic [2:0] {S_IDLE, S_P_RD, S_P_EV, S_M_RD, S_M_WR} state_t;

  state_t     state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic [4:0] pass_r, pass_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    cmd.k     = k_r;
    cmd.pass  = pass_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_go) begin
          state_nxt = S_P_RD;
          k_nxt     = aecd_pkg::NBR_CENTER;
          pass_nxt  = '0;
        end
      end
      S_P_RD: begin
        cmd.dil   = 1'b1;
        cmd.rd    = 1'b1;
        state_nxt = S_P_EV;
      end
      S_P_EV: begin
        cmd.dil   = 1'b1;
        cmd.eval  = 1'b1;
        state_nxt = S_P_RD;
        if (sts.opaque || k_r == aecd_pkg::NBR_DOWN) begin
          // settle this pixel
          cmd.wr_center = (k_r == aecd_pkg::NBR_CENTER) || !sts.opaque;
          cmd.wr_nbr    = (k_r != aecd_pkg::NBR_CENTER) && sts.opaque;
          cmd.adv       = 1'b1;
          k_nxt         = aecd_pkg::NBR_CENTER;
          if (sts.last_pixel) begin
            if (pass_r == {sts.pass_pairs, 1'b0}) begin
              state_nxt = S_M_RD;
            end else begin
              pass_nxt = pass_r + 5'd1;
            end
          end
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_M_RD: begin
        cmd.merge = 1'b1;
        state_nxt = S_M_WR;
      end
      S_M_WR: begin
        cmd.merge  = 1'b1;
        cmd.mrg_wr = 1'b1;
        cmd.adv    = 1'b1;
        state_nxt  = sts.last_pixel ? S_IDLE : S_M_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= aecd_pkg::NBR_CENTER;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      pass_r  <= pass_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* hw/rtl/aecd_dp.sv */
// ----------------------------------------------------------------------------
// aecd_dp
// Pixel stores, pointers, neighbor addressing and the opacity test.
// ----------------------------------------------------------------------------
module aecd_dp #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  aecd_pkg::cfg_t     cfg,
  input  logic               in_accept,
  input  aecd_pkg::pixel_in_t in_data,
  input  logic               job_go,
  input  aecd_pkg::cmd_t     cmd,
  output aecd_pkg::sts_t     sts,
  output logic               out_valid,
  output aecd_pkg::pixel_out_t out_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);

  logic [31:0] orig_mem [DEPTH];
  logic [31:0] pp_mem   [2*DEPTH];
  logic [31:0] orig_q, pp_q, rdata, ctr_r;

  logic [WW-1:0] w_live, w_s;
  logic [HW-1:0] h_live, h_s;
  logic [NW-1:0] n_live, n_s;
  logic [7:0]    th_s;
  logic [3:0]    pairs_s;

  logic [NW-1:0] lptr_r, lptr_nxt, fptr_r, fptr_nxt, idx_r, idx_nxt;
  logic [WW-1:0] x_r, x_nxt;
  logic [HW-1:0] y_r, y_nxt;
  logic          ready_r, ready_nxt, out_valid_r, out_last_r;

  logic [NW-1:0] l_ptr, f_addr, paddr, w_ext;
  logic          l_ok, f_last, is_load, is_fetch;
  logic [AW-1:0] orig_ra, orig_wa;
  logic [AW:0]   pp_ra, pp_wa;
  logic          orig_we, pp_we;
  logic [31:0]   orig_wd, pp_wd;

  // clamp dimensions: zero acts as one, above maximum acts as maximum
  always_comb begin
    if (cfg.image_width == 7'd0) w_live = WW'(1);
    else if (32'(cfg.image_width) > MAX_WIDTH) w_live = WW'(MAX_WIDTH);
    else w_live = WW'(cfg.image_width);
    if (cfg.image_height == 7'd0) h_live = HW'(1);
    else if (32'(cfg.image_height) > MAX_HEIGHT) h_live = HW'(MAX_HEIGHT);
    else h_live = HW'(cfg.image_height);
    n_live = NW'(w_live) * NW'(h_live);
  end

  assign is_load  = in_accept && in_data.req_type == aecd_pkg::REQ_LOAD;
  assign is_fetch = in_accept && in_data.req_type == aecd_pkg::REQ_FETCH;

  assign l_ptr  = ready_r ? '0 : lptr_r;
  assign l_ok   = l_ptr < n_live;
  assign f_addr = (fptr_r >= n_live) ? '0 : fptr_r;
  assign f_last = f_addr == n_live - NW'(1);

  // neighbor address with edge clamping
  assign w_ext = NW'(w_s);
  always_comb begin
    case (cmd.k)
      aecd_pkg::NBR_UP:    paddr = (y_r == '0) ? idx_r : idx_r - w_ext;
      aecd_pkg::NBR_LEFT:  paddr = (x_r == '0) ? idx_r : idx_r - NW'(1);
      aecd_pkg::NBR_RIGHT: paddr = (x_r == w_s - WW'(1)) ? idx_r : idx_r + NW'(1);
      aecd_pkg::NBR_DOWN:  paddr = (y_r == h_s - HW'(1)) ? idx_r : idx_r + w_ext;
      default:             paddr = idx_r;
    endcase
  end

  always_comb begin
    if (cmd.merge)    orig_ra = idx_r[AW-1:0];
    else if (cmd.dil) orig_ra = paddr[AW-1:0];
    else              orig_ra = f_addr[AW-1:0];
    pp_ra = cmd.merge ? {1'b0, idx_r[AW-1:0]} : {~cmd.pass[0], paddr[AW-1:0]};

    orig_we = (is_load && l_ok) || (cmd.mrg_wr && orig_q[31:24] == aecd_pkg::ALPHA_CLEAR);
    orig_wa = cmd.mrg_wr ? idx_r[AW-1:0] : l_ptr[AW-1:0];
    orig_wd = cmd.mrg_wr ? {aecd_pkg::ALPHA_CLEAR, pp_q[23:0]}
                         : {in_data.in_alpha, in_data.in_blue, in_data.in_green,
                            in_data.in_red};

    rdata = (cmd.pass == '0) ? orig_q : pp_q;
    pp_we = cmd.wr_center || cmd.wr_nbr;
    pp_wa = {cmd.pass[0], idx_r[AW-1:0]};
    if (cmd.wr_nbr) pp_wd = {aecd_pkg::ALPHA_OPAQUE, rdata[23:0]};
    else pp_wd = (cmd.k == aecd_pkg::NBR_CENTER) ? rdata : ctr_r;
  end

  always_ff @(posedge clk) begin
    if (orig_we) orig_mem[orig_wa] <= orig_wd;
    orig_q <= orig_mem[orig_ra];
  end

  always_ff @(posedge clk) begin
    if (pp_we) pp_mem[pp_wa] <= pp_wd;
    pp_q <= pp_mem[pp_ra];
  end

  // pointers and pixel walk
  always_comb begin
    ready_nxt = ready_r;
    lptr_nxt  = lptr_r;
    fptr_nxt  = fptr_r;
    idx_nxt   = idx_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    if (is_load) begin
      lptr_nxt  = l_ok ? l_ptr + NW'(1) : l_ptr;
      ready_nxt = 1'b0;
      if (in_data.in_last) begin
        lptr_nxt  = '0;
        fptr_nxt  = '0;
        ready_nxt = 1'b1;
      end
    end
    if (is_fetch && ready_r) fptr_nxt = f_last ? '0 : f_addr + NW'(1);
    if (job_go || (cmd.adv && sts.last_pixel)) begin
      idx_nxt = '0;
      x_nxt   = '0;
      y_nxt   = '0;
    end else if (cmd.adv) begin
      idx_nxt = idx_r + NW'(1);
      if (x_r == w_s - WW'(1)) begin
        x_nxt = '0;
        y_nxt = y_r + HW'(1);
      end else begin
        x_nxt = x_r + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= 1'b0;
      lptr_r      <= '0;
      fptr_r      <= '0;
      idx_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ready_r     <= ready_nxt;
      lptr_r      <= lptr_nxt;
      fptr_r      <= fptr_nxt;
      idx_r       <= idx_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      out_valid_r <= is_fetch && ready_r;
    end
  end

  // job settings and held center pixel
  always_ff @(posedge clk) begin
    if (job_go) begin
      w_s     <= w_live;
      h_s     <= h_live;
      n_s     <= n_live;
      th_s    <= cfg.alpha_threshold;
      pairs_s <= cfg.pass_pairs;
    end
    if (cmd.eval && cmd.k == aecd_pkg::NBR_CENTER) ctr_r <= rdata;
    out_last_r <= f_last;
  end

  assign sts.opaque     = rdata[31:24] > th_s;
  assign sts.last_pixel = idx_r == n_s - NW'(1);
  assign sts.pass_pairs = pairs_s;

  assign out_valid          = out_valid_r;
  assign out_data.out_red   = orig_q[7:0];
  assign out_data.out_green = orig_q[15:8];
  assign out_data.out_blue  = orig_q[23:16];
  assign out_data.out_alpha = orig_q[31:24];
  assign out_data.out_last  = out_last_r;

endmodule

/* hw/rtl/alpha_edge_color_dilation.sv */
// ----------------------------------------------------------------------------
// alpha_edge_color_dilation
// Loads an RGBA image, bleeds opaque color into transparent edges, and
// returns the image with the new color under its original alpha.
// ----------------------------------------------------------------------------
// A load or fetch word is taken whenever busy is low. The load word with
// in_last set starts the computation and raises busy: the block runs
// 1 + 2*pass_pairs dilation passes over width*height pixels, reading and
// testing each pixel once if it is already opaque and otherwise searching
// up to all four neighbors (one registered read of the pixel store per
// neighbor, each read followed by a state that tests it), then a merge
// sweep over every pixel. Busy drops when the merge ends. A fetch returns
// its pixel on out_data in the cycle after acceptance with out_valid high
// for exactly that cycle; the receiver cannot stall it, so capture it
// then. Fetches before the first finished image give nothing. Write
// configuration only while idle.
module alpha_edge_color_dilation #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  aecd_pkg::pixel_in_t  in_data,
  output logic                 out_valid,
  output aecd_pkg::pixel_out_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata
);

  aecd_pkg::cfg_t cfg_r, cfg_nxt;
  aecd_pkg::cmd_t cmd;
  aecd_pkg::sts_t sts;
  logic           in_accept, job_go;

  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;
  // hand the passes to the sequencer on the closing load word
  assign job_go = in_accept && in_data.req_type == aecd_pkg::REQ_LOAD && in_data.in_last;

  // decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aecd_pkg::REG_IMAGE_WIDTH:     cfg_nxt.image_width     = cfg_wdata[6:0];
        aecd_pkg::REG_IMAGE_HEIGHT:    cfg_nxt.image_height    = cfg_wdata[6:0];
        aecd_pkg::REG_ALPHA_THRESHOLD: cfg_nxt.alpha_threshold = cfg_wdata;
        aecd_pkg::REG_PASS_PAIRS:      cfg_nxt.pass_pairs      = cfg_wdata[3:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= aecd_pkg::RST_IMAGE_WIDTH;
      cfg_r.image_height    <= aecd_pkg::RST_IMAGE_HEIGHT;
      cfg_r.alpha_threshold <= aecd_pkg::RST_ALPHA_THRESHOLD;
      cfg_r.pass_pairs      <= aecd_pkg::RST_PASS_PAIRS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  aecd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .job_go (job_go),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  aecd_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_accept (in_accept),
    .in_data   (in_data),
    .job_go    (job_go),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // a result word only follows an accepted fetch
  a_out_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept && in_data.req_type == aecd_pkg::REQ_FETCH))
    else $error("result word without fetch");

  // computation starts only on the closing load word
  a_busy_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(job_go))
    else $error("busy rose without final load word");

  // no result word while the passes run
  a_quiet_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy && $past(busy) |-> !out_valid)
    else $error("result word during computation");
`endif

endmodule

/* tb/sv/aecd_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aecd_checker
// Watches the load/fetch, result and configuration channels, mirrors the
// dilation image stores and compares every returned pixel with its forecast.
// ----------------------------------------------------------------------------
module aecd_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  aecd_pkg::pixel_in_t  in_data,
  input  logic                 out_valid,
  input  aecd_pkg::pixel_out_t out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_wdata,
  output int                   errors,
  output int                   pending,
  output int                   results
);

  localparam int DEPTH = 4096;
  localparam int ORG = 0, PING = 1, PONG = 2;
  localparam int DX [4] = '{0, -1, 1, 0};
  localparam int DY [4] = '{-1, 0, 0, 1};

  typedef enum logic {ST_LOADING, ST_READY} img_phase_t;

  // pixel words: {alpha, blue, green, red}
  logic [31:0]          pix_mem [3][DEPTH];
  aecd_pkg::cfg_t       cfg_m;
  img_phase_t           img_phase;
  int                   load_ptr;
  int                   fetch_ptr;
  aecd_pkg::pixel_out_t px_expected [$];

  function automatic int eff_dim(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return int'(v);
  endfunction

  function automatic void bleed_pass(int s, int d, int w, int h);
    int          nx, ny;
    logic [31:0] px, np;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        px = pix_mem[s][y*w+x];
        pix_mem[d][y*w+x] = px;
        if (px[31:24] > cfg_m.alpha_threshold) continue;
        for (int k = 0; k < 4; k++) begin
          nx = x + DX[k];
          ny = y + DY[k];
          nx = (nx < 0) ? 0 : (nx >= w) ? w - 1 : nx;
          ny = (ny < 0) ? 0 : (ny >= h) ? h - 1 : ny;
          np = pix_mem[s][ny*w+nx];
          if (np[31:24] > cfg_m.alpha_threshold) begin
            pix_mem[d][y*w+x] = {aecd_pkg::ALPHA_OPAQUE, np[23:0]};
            break;
          end
        end
      end
    end
  endfunction

  function automatic void run_dilation();
    int w, h;
    w = eff_dim(cfg_m.image_width);
    h = eff_dim(cfg_m.image_height);
    bleed_pass(ORG, PING, w, h);
    for (int i = 0; i < cfg_m.pass_pairs; i++) begin
      bleed_pass(PING, PONG, w, h);
      bleed_pass(PONG, PING, w, h);
    end
    for (int i = 0; i < w*h; i++)
      if (pix_mem[ORG][i][31:24] == aecd_pkg::ALPHA_CLEAR)
        pix_mem[ORG][i] = {aecd_pkg::ALPHA_CLEAR, pix_mem[PING][i][23:0]};
  endfunction

  function automatic void take_word(aecd_pkg::pixel_in_t wd);
    int                   n;
    logic [31:0]          px;
    aecd_pkg::pixel_out_t r;
    n = eff_dim(cfg_m.image_width) * eff_dim(cfg_m.image_height);
    if (wd.req_type == aecd_pkg::REQ_LOAD) begin
      if (img_phase != ST_LOADING) begin
        img_phase = ST_LOADING;
        load_ptr  = 0;
      end
      if (load_ptr < n) begin
        pix_mem[ORG][load_ptr] = {wd.in_alpha, wd.in_blue, wd.in_green, wd.in_red};
        load_ptr++;
      end
      if (wd.in_last) begin
        run_dilation();
        img_phase = ST_READY;
        load_ptr  = 0;
        fetch_ptr = 0;
      end
    end else if (img_phase == ST_READY) begin
      if (fetch_ptr >= n) fetch_ptr = 0;
      px          = pix_mem[ORG][fetch_ptr];
      r.out_red   = px[7:0];
      r.out_green = px[15:8];
      r.out_blue  = px[23:16];
      r.out_alpha = px[31:24];
      r.out_last  = (fetch_ptr == n - 1);
      fetch_ptr   = r.out_last ? 0 : fetch_ptr + 1;
      px_expected.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    aecd_pkg::pixel_out_t e;
    if (!rst_n) begin
      cfg_m     <= '{aecd_pkg::RST_IMAGE_WIDTH, aecd_pkg::RST_IMAGE_HEIGHT,
                     aecd_pkg::RST_ALPHA_THRESHOLD, aecd_pkg::RST_PASS_PAIRS};
      img_phase = ST_LOADING;
      load_ptr  = 0;
      fetch_ptr = 0;
      px_expected.delete();
      errors    <= 0;
      results   <= 0;
    end else begin
      if (out_valid) begin
        results <= results + 1;
        if (px_expected.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("checker: unexpected pixel %h", out_data);
        end else begin
          e = px_expected.pop_front();
          if (out_data !== e) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("checker: pixel mismatch exp r%h g%h b%h a%h l%b got r%h g%h b%h a%h l%b",
                       e.out_red, e.out_green, e.out_blue, e.out_alpha, e.out_last,
                       out_data.out_red, out_data.out_green, out_data.out_blue,
                       out_data.out_alpha, out_data.out_last);
          end
        end
      end
      if (start && !busy) take_word(in_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aecd_pkg::REG_IMAGE_WIDTH:     cfg_m.image_width     <= cfg_wdata[6:0];
          aecd_pkg::REG_IMAGE_HEIGHT:    cfg_m.image_height    <= cfg_wdata[6:0];
          aecd_pkg::REG_ALPHA_THRESHOLD: cfg_m.alpha_threshold <= cfg_wdata;
          aecd_pkg::REG_PASS_PAIRS:      cfg_m.pass_pairs      <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
    pending = px_expected.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives images through the alpha edge dilation block under many register
// settings and leaves the pixel checks to the checker beside it.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RAND_WORDS  = 1800;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  aecd_pkg::pixel_in_t  in_data;
  logic                 out_valid;
  aecd_pkg::pixel_out_t out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [7:0]           cfg_wdata;
  int                   errors, pending, results;

  // stimulus-side view of the registers and of the loaded store
  logic [7:0] cur_w, cur_h, cur_thr, cur_pp;
  int         written;   // store entries 0..written-1 hold loaded data
  bit         img_ready; // a computed image is waiting for fetches
  bit         idle_on;
  int         words, images;
  int         cycles = 0;

  alpha_edge_color_dilation u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  aecd_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .results(results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int eff_dim(logic [7:0] v);
    if (v[6:0] == 0) return 1;
    if (v[6:0] > 64) return 64;
    return int'(v[6:0]);
  endfunction

  function automatic int pix_count();
    return eff_dim(cur_w) * eff_dim(cur_h);
  endfunction

  // Drive one word at the falling edge and hold it until accepted. An
  // optional idle burst comes first; start is assigned once per falling edge.
  task automatic send_word(aecd_pkg::pixel_in_t wd);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= wd;
    @(posedge clk);
    while (busy) @(posedge clk);
    words++;
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return aecd_pkg::ALPHA_CLEAR;
      1: return aecd_pkg::ALPHA_OPAQUE;
      2: return cur_thr;
      3: return cur_thr + 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Load cnt pixels, last flag on the final one. Stray fetches are mixed in
  // only after the first pixel, while the block ignores them.
  task automatic load_image(int cnt);
    aecd_pkg::pixel_in_t wd;
    for (int i = 0; i < cnt; i++) begin
      wd.req_type = aecd_pkg::REQ_LOAD;
      wd.in_red   = 8'($urandom_range(0, 255));
      wd.in_green = 8'($urandom_range(0, 255));
      wd.in_blue  = 8'($urandom_range(0, 255));
      wd.in_alpha = pick_alpha();
      wd.in_last  = (i == cnt - 1);
      send_word(wd);
      if (i > 0 && i < cnt - 1 && $urandom_range(0, 9) == 0) begin
        wd          = aecd_pkg::pixel_in_t'({2'b00, $urandom()});
        wd.req_type = aecd_pkg::REQ_FETCH;
        send_word(wd);
      end
    end
    if (cnt > written) written = (cnt > pix_count()) ? pix_count() : cnt;
    img_ready = 1'b1;
    images++;
  endtask

  task automatic fetch_pixels(int cnt);
    aecd_pkg::pixel_in_t wd;
    for (int i = 0; i < cnt; i++) begin
      wd          = aecd_pkg::pixel_in_t'({2'b00, $urandom()});
      wd.req_type = aecd_pkg::REQ_FETCH;
      send_word(wd);
    end
  endtask

  // Hold off the sender until every forecast pixel is back and the block is idle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      aecd_pkg::REG_IMAGE_WIDTH:     cur_w   = val;
      aecd_pkg::REG_IMAGE_HEIGHT:    cur_h   = val;
      aecd_pkg::REG_ALPHA_THRESHOLD: cur_thr = val;
      default:                       cur_pp  = val;
    endcase
  endtask

  task automatic set_all(logic [7:0] w, logic [7:0] h, logic [7:0] thr, logic [7:0] pp);
    write_reg(aecd_pkg::REG_IMAGE_WIDTH, w);
    write_reg(aecd_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(aecd_pkg::REG_ALPHA_THRESHOLD, thr);
    write_reg(aecd_pkg::REG_PASS_PAIRS, pp);
  endtask

  initial begin
    logic [7:0] w, h, thr, pp;
    int         n, cnt;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = aecd_pkg::REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    words     = 0;
    images    = 0;
    written   = 0;
    img_ready = 1'b0;
    idle_on   = 1'b1;
    cur_w     = 8'(aecd_pkg::RST_IMAGE_WIDTH);
    cur_h     = 8'(aecd_pkg::RST_IMAGE_HEIGHT);
    cur_thr   = aecd_pkg::RST_ALPHA_THRESHOLD;
    cur_pp    = 8'(aecd_pkg::RST_PASS_PAIRS);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero dimensions act as one pixel, fetch wraps onto itself
    set_all(8'd0, 8'd0, 8'd0, 8'd0);
    load_image(1);
    fetch_pixels(2);
    drain();
    // nothing opaque at the top threshold, longest pass chain
    set_all(8'd3, 8'd2, 8'd255, 8'd15);
    load_image(6);
    fetch_pixels(6);
    drain();
    // mixed alphas, fetch past the end, then reload while results are ready
    write_reg(aecd_pkg::REG_ALPHA_THRESHOLD, 8'd10);
    load_image(6);
    fetch_pixels(7);
    load_image(8);   // overflow: two extra pixels are dropped
    fetch_pixels(3);
    drain();
    // shrink after compute: fetch pointer past the new count restarts at 0
    write_reg(aecd_pkg::REG_IMAGE_HEIGHT, 8'd1);
    fetch_pixels(4);
    drain();

    // random phases over many register settings
    while (words < RAND_WORDS) begin
      if (words > RAND_WORDS * 9 / 10) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0: begin w = 8'd64;  h = 8'($urandom_range(0, 2)); end
        1: begin h = 8'd127; w = 8'($urandom_range(1, 2)); end
        2: begin w = 8'd127; h = 8'd1; end
        default: begin w = 8'($urandom_range(0, 8)); h = 8'($urandom_range(0, 8)); end
      endcase
      thr = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0)
                                        : 8'($urandom_range(0, 255));
      pp  = 8'($urandom_range(0, 3));
      if (eff_dim(w) * eff_dim(h) <= 16 && $urandom_range(0, 5) == 0) pp = 8'd15;
      if ($urandom_range(0, 3) == 0) pp = pp | 8'hF0; // upper bits dropped
      set_all(w, h, thr, pp);
      n = pix_count();
      // fetch an older image under the new size, if its entries exist
      if (img_ready && n <= written && $urandom_range(0, 4) == 0)
        fetch_pixels($urandom_range(1, n + 2));
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 5))
          0: cnt = (n > 1 && n <= written) ? $urandom_range(1, n - 1) : n;
          1: cnt = n + $urandom_range(1, 3);
          default: cnt = n;
        endcase
        load_image(cnt);
        fetch_pixels($urandom_range(0, 2 * n));
      end
      drain();
    end
    drain();

    $display("tb: %0d words sent, %0d images dilated, %0d pixels checked",
             words, images, results);
    $display("tb: sizes from 1x1 to 64 wide/tall, thresholds 0..255, up to 15 pass pairs");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
